// ===== rtl/opgrm_pkg.sv =====
// Package for the outer-product gradient running-mean unit.
// Shared constants, types and arithmetic helpers; no dependencies.
`default_nettype none
package opgrm_pkg;
  localparam int unsigned OutputRowsDefault   = 64;
  localparam int unsigned InputColumnsDefault = 64;
  localparam int unsigned Lanes               = 4;
  localparam int unsigned DataW               = 32;
  localparam int unsigned CountW              = 16;
  localparam int unsigned GroupW              = 4;
  localparam int unsigned ColW                = 6;
  localparam int unsigned DiffW               = 33;
  localparam int unsigned FracBits            = 24;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd2147483647;
    lo = -34'sd2147483648;
    if (v > hi) sat34 = 32'sh7fffffff;
    else if (v < lo) sat34 = 32'sh80000000;
    else sat34 = v[31:0];
  endfunction

  // Shift the Q16.48 product down and saturate to Q8.24.
  function automatic logic signed [31:0] prod_sat(input logic signed [63:0] p);
    logic signed [39:0] s;
    s = p[63:24];
    if (s > 40'sd2147483647) prod_sat = 32'sh7fffffff;
    else if (s < -40'sd2147483648) prod_sat = 32'sh80000000;
    else prod_sat = s[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/opgrm_div.sv =====
// Pipelined signed divider: 33-bit dividend by 16-bit unsigned divisor,
// quotient truncated toward zero, one quotient bit per stage. Uses opgrm_pkg.
`default_nettype none
module opgrm_div
  import opgrm_pkg::*;
#(
  parameter int unsigned TagW = 1
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [DiffW-1:0]      dividend,
  input  wire logic [CountW-1:0]     divisor,
  input  wire logic [TagW-1:0]       tag_in,
  output logic signed [DiffW-1:0]    quotient,
  output logic [TagW-1:0]            tag_out
);
  localparam int unsigned Stages = DiffW;

  logic [DiffW-1:0]  rem_r [Stages+1];
  logic [DiffW-1:0]  quo_r [Stages+1];
  logic [CountW-1:0] dvs_r [Stages+1];
  logic              neg_r [Stages+1];
  logic [TagW-1:0]   tag_r [Stages+1];

  // Stage 0: take the magnitude of the dividend
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      quo_r[0] <= dividend[DiffW-1] ? (~dividend + 1'b1) : dividend;
      dvs_r[0] <= divisor;
      neg_r[0] <= dividend[DiffW-1];
      tag_r[0] <= tag_in;
    end
  end

  // One restoring step per stage
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [DiffW:0] trial;
    logic [DiffW-1:0] shifted;
    always_comb begin
      shifted = {rem_r[s][DiffW-2:0], quo_r[s][DiffW-1]};
      trial   = {1'b0, shifted} - {{(DiffW+1-CountW){1'b0}}, dvs_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= trial[DiffW] ? shifted : trial[DiffW-1:0];
        quo_r[s+1] <= {quo_r[s][DiffW-2:0], ~trial[DiffW]};
        dvs_r[s+1] <= dvs_r[s];
        neg_r[s+1] <= neg_r[s];
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  assign quotient = neg_r[Stages] ? -$signed(quo_r[Stages]) : $signed(quo_r[Stages]);
  assign tag_out  = tag_r[Stages];
endmodule
`default_nettype wire

// ===== rtl/opgrm_lane.sv =====
// One lane: product, difference against the stored mean, pipelined divide
// and saturating add for the weight and the bias entry. Uses opgrm_pkg, opgrm_div.
`default_nettype none
module opgrm_lane
  import opgrm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] grad,
  input  wire logic signed [31:0] x,
  input  wire logic [CountW-1:0]  n,
  input  wire logic signed [31:0] w_old,
  input  wire logic signed [31:0] b_old,
  output logic signed [31:0]      w_new,
  output logic signed [31:0]      b_new
);
  logic signed [63:0] prod_r;
  logic signed [31:0] g_r, w0_r, b0_r;
  logic [CountW-1:0]  n_r;
  logic signed [DiffW-1:0] dw, db, qw, qb;
  logic signed [31:0] wold_o, bold_o, bold_x;

  // Product stage
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(grad) * 64'(x);
      g_r    <= grad;
      w0_r   <= w_old;
      b0_r   <= b_old;
      n_r    <= (n == '0) ? CountW'(1) : n;
    end
  end

  assign dw = DiffW'(prod_sat(prod_r)) - DiffW'(w0_r);
  assign db = DiffW'(g_r) - DiffW'(b0_r);

  opgrm_div #(.TagW(32)) u_dw (.clk, .en, .dividend(dw), .divisor(n_r),
    .tag_in(w0_r), .quotient(qw), .tag_out(wold_o));
  opgrm_div #(.TagW(32)) u_db (.clk, .en, .dividend(db), .divisor(n_r),
    .tag_in(b0_r), .quotient(qb), .tag_out(bold_o));
  assign bold_x = bold_o;

  assign w_new = sat34(34'(wold_o) + 34'(qw));
  assign b_new = sat34(34'(bold_x) + 34'(qb));
endmodule
`default_nettype wire

// ===== rtl/outer_product_gradient_running_mean_unit.sv =====
// Outer-product gradient running-mean unit, top level.
// Uses opgrm_pkg, opgrm_lane, opgrm_div.
//
// Input channel in_*: one transaction carries a row group, a column, four
// output gradients, a layer input and the sample count. Output channel out_*
// returns the four updated weight-gradient entries and four bias entries.
// From input accept to output valid a transaction passes the input register,
// store read, product, 34 divider stages and the output queue.
// Throughput: one transaction per cycle while transactions touch distinct
// entries and the output queue has room. A transaction waits in the input
// register while an earlier one on the same weight entry, or any column-0
// transaction sharing a valid lane, is still in the 36-stage pipeline.
// Stores: weights in one memory per lane (groups x columns), biases in one
// register bank per lane. The weight memories are cleared after reset by a
// sweep over all ceil(OUTPUT_ROWS/4)*INPUT_COLUMNS entries (1024 by default),
// during which in_tready stays low.
// A two-entry output queue absorbs receiver stalls; the pipeline holds only
// when the queue is full and a result is ready, so in_tready never depends
// on out_tready in the same cycle.
// Reset is synchronous, active low; it clears control state and biases.
`default_nettype none
module outer_product_gradient_running_mean_unit
  import opgrm_pkg::*;
#(
  parameter int unsigned OUTPUT_ROWS   = OutputRowsDefault,
  parameter int unsigned INPUT_COLUMNS = InputColumnsDefault
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // row_group[3:0], column[9:4], grad_lane0..3[137:10], input_value[169:138],
  // sample_count[185:170], zero pad[191:186]
  input  wire logic [191:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // weight_lane0..3[127:0], bias_lane0..3[255:128]
  output logic [255:0]      out_tdata
);
  localparam int unsigned Groups = (OUTPUT_ROWS + Lanes - 1) / Lanes;
  localparam int unsigned Depth  = Groups * INPUT_COLUMNS;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Lat    = DiffW + 3;  // read, product, divider stages

  // Field unpack
  logic [GroupW-1:0] grp;
  logic [ColW-1:0]   col;
  logic signed [31:0] gin [Lanes];
  logic signed [31:0] xin;
  logic [CountW-1:0]  nin;
  assign grp = in_tdata[3:0];
  assign col = in_tdata[9:4];
  for (genvar l = 0; l < Lanes; l++) begin : g_unp
    assign gin[l] = in_tdata[10+32*l +: 32];
  end
  assign xin = in_tdata[169:138];
  assign nin = in_tdata[185:170];

  // Clearing sweep
  logic             clr_r;
  logic [AddrW:0]   clr_cnt_r;
  logic             adv;          // pipeline advances
  logic             acc;
  logic [1:0]       skid_cnt_r;
  logic             pipe_room;

  // Stage A: accepted item with address, lane validity
  logic             a_v_r;
  logic [AddrW-1:0] a_addr_r;
  logic             a_wok_r;
  logic             a_col0_r;
  logic [Lanes-1:0] a_rok_r;
  logic [GroupW-1:0] a_grp_r;
  logic signed [31:0] a_g_r [Lanes];
  logic signed [31:0] a_x_r;
  logic [CountW-1:0]  a_n_r;

  // Shift line of control info across the arithmetic
  typedef struct packed {
    logic             v;
    logic [AddrW-1:0] addr;
    logic             wok;
    logic             col0;
    logic [Lanes-1:0] rok;
  } ctl_t;
  ctl_t ctl_r [Lat];
  logic [GroupW-1:0] grp_r [Lat];

  logic signed [31:0] mem [Lanes][Depth];
  logic signed [31:0] rd_r [Lanes];
  logic signed [31:0] bias_r [Lanes][Groups];
  logic signed [31:0] w_new [Lanes];
  logic signed [31:0] b_new [Lanes];
  logic signed [31:0] w_old [Lanes];
  logic signed [31:0] b_old [Lanes];

  // Same-address or column-0 items still in the pipeline; a hit must wait (stall)
  logic hazard;
  always_comb begin
    hazard = 1'b0;
    for (int s = 0; s < Lat; s++) begin
      if (ctl_r[s].v && (ctl_r[s].addr == a_addr_r) && ctl_r[s].wok && a_wok_r)
        hazard = 1'b1;
      if (ctl_r[s].v && ctl_r[s].col0)
        for (int l = 0; l < Lanes; l++)
          if (a_v_r && ctl_r[s].rok[l] && a_rok_r[l]) hazard = 1'b1;
    end
    if (!a_v_r) hazard = 1'b0;
  end

  logic last_v;
  assign last_v    = ctl_r[Lat-1].v;
  assign pipe_room = (skid_cnt_r != 2'd2) || !last_v;
  assign adv       = pipe_room;
  assign in_tready = !clr_r && adv && (!a_v_r || !hazard);
  assign acc       = in_tvalid && in_tready;

  // Sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + (AddrW+1)'(1);
      if (clr_cnt_r == (AddrW+1)'(Depth - 1)) clr_r <= 1'b0;
    end
  end

  // Stage A capture
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv && !(a_v_r && hazard)) a_v_r <= acc;
  end
  always_ff @(posedge clk) begin
    if (acc) begin
      a_addr_r <= AddrW'(32'(grp) * INPUT_COLUMNS + 32'(col));
      a_wok_r  <= 32'(col) < INPUT_COLUMNS && 32'(grp) < Groups;
      a_col0_r <= (col == '0);
      a_grp_r  <= grp;
      for (int l = 0; l < Lanes; l++) begin
        a_rok_r[l] <= (32'(grp) * Lanes + l) < OUTPUT_ROWS;
        a_g_r[l]   <= gin[l];
      end
      a_x_r <= xin;
      a_n_r <= nin;
    end
  end

  // Memory read and shift line
  logic go;
  assign go = adv && a_v_r && !hazard;
  for (genvar l = 0; l < Lanes; l++) begin : g_mem
    always_ff @(posedge clk) begin
      if (adv) rd_r[l] <= mem[l][a_addr_r];
      if (clr_r) mem[l][clr_cnt_r[AddrW-1:0]] <= '0;
      else if (adv && ctl_r[Lat-1].v && ctl_r[Lat-1].wok && ctl_r[Lat-1].rok[l])
        mem[l][ctl_r[Lat-1].addr] <= w_new[l];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < Lat; s++) ctl_r[s].v <= 1'b0;
    end else if (adv) begin
      ctl_r[0].v <= go;
      for (int s = 1; s < Lat; s++) ctl_r[s].v <= ctl_r[s-1].v;
    end
    if (adv) begin
      ctl_r[0].addr <= a_addr_r;
      ctl_r[0].wok  <= a_wok_r;
      ctl_r[0].col0 <= a_col0_r;
      ctl_r[0].rok  <= a_rok_r;
      grp_r[0]      <= a_grp_r;
      for (int s = 1; s < Lat; s++) begin
        ctl_r[s].addr <= ctl_r[s-1].addr;
        ctl_r[s].wok  <= ctl_r[s-1].wok;
        ctl_r[s].col0 <= ctl_r[s-1].col0;
        ctl_r[s].rok  <= ctl_r[s-1].rok;
        grp_r[s]      <= grp_r[s-1];
      end
    end
  end

  // Lane inputs registered once more after stage A (aligned with memory read data)
  logic signed [31:0] g1_r [Lanes];
  logic signed [31:0] x1_r;
  logic [CountW-1:0]  n1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      g1_r <= a_g_r;
      x1_r <= a_x_r;
      n1_r <= a_n_r;
      for (int l = 0; l < Lanes; l++) b_old[l] <= bias_r[l][a_grp_r];
    end
  end
  assign w_old = rd_r;

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    opgrm_lane u_lane (.clk, .en(adv), .grad(g1_r[l]), .x(x1_r), .n(n1_r),
      .w_old(w_old[l]), .b_old(b_old[l]), .w_new(w_new[l]), .b_new(b_new[l]));
  end

  // Merge stage: bias write-back and result assembly
  logic [255:0] res;
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      res[32*l +: 32]       = (ctl_r[Lat-1].wok && ctl_r[Lat-1].rok[l]) ? w_new[l] : '0;
      res[128+32*l +: 32]   = !ctl_r[Lat-1].rok[l] ? 32'sd0 :
                              ctl_r[Lat-1].col0 ? b_new[l] : bias_r[l][grp_r[Lat-1]];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < Lanes; l++)
        for (int r = 0; r < Groups; r++) bias_r[l][r] <= '0;
    end else if (adv && last_v && ctl_r[Lat-1].col0) begin
      for (int l = 0; l < Lanes; l++)
        if (ctl_r[Lat-1].rok[l]) bias_r[l][grp_r[Lat-1]] <= b_new[l];
    end
  end

  // Two-entry output queue
  logic [255:0] q_r [2];
  logic push, pop, push_head;
  assign push = adv && last_v;
  assign pop  = out_tvalid && out_tready;
  assign push_head = push && (skid_cnt_r == 2'd0 || (skid_cnt_r == 2'd1 && pop));
  always_ff @(posedge clk) begin
    if (!rst_n) skid_cnt_r <= '0;
    else skid_cnt_r <= skid_cnt_r + {1'b0, push} - {1'b0, pop};
  end
  always_ff @(posedge clk) begin
    if (push_head) q_r[0] <= res;
    else if (pop) q_r[0] <= q_r[1];
    if (push && !push_head) q_r[1] <= res;
  end
  assign out_tvalid = (skid_cnt_r != 2'd0);
  assign out_tdata  = q_r[0];

  // Checks
  a_qbound: assert property (@(posedge clk) disable iff (!rst_n)
    skid_cnt_r != 2'd3) else $error("output queue overflow");
  a_noclr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_tready) else $error("input taken during clearing sweep");
  a_nohaz: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && hazard) |-> !in_tready) else $error("input taken while hazard held");
endmodule
`default_nettype wire

// ===== test/outer_product_gradient_running_mean_unit_tb.sv =====
// Testbench for the outer-product gradient running-mean unit.
// Predicts each result from its own copy of the weight and bias stores and
// checks out_tdata field by field. Depends on opgrm_pkg and the top level.
`default_nettype none
module outer_product_gradient_running_mean_unit_tb;
  import opgrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Rows = 64;
  localparam int Cols = 64;
  localparam int NumDirected = 20;
  localparam int NumRandom = 1100;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [15:0]        count;
    logic signed [31:0] x;
    logic signed [31:0] g3;
    logic signed [31:0] g2;
    logic signed [31:0] g1;
    logic signed [31:0] g0;
    logic [5:0]         col;
    logic [3:0]         grp;
  } grad_item_t;

  typedef struct packed {
    logic signed [31:0] b3;
    logic signed [31:0] b2;
    logic signed [31:0] b1;
    logic signed [31:0] b0;
    logic signed [31:0] w3;
    logic signed [31:0] w2;
    logic signed [31:0] w1;
    logic signed [31:0] w0;
  } grad_result_t;

  // directed table row; fixed result only where obvious
  typedef struct {
    grad_item_t   item;
    bit           has_fixed;
    grad_result_t fixed;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;

  outer_product_gradient_running_mean_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] weight_mean [Rows*Cols];
  logic signed [31:0] bias_mean [Rows];
  grad_result_t expected_results[$];
  int mismatches = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] mean_update(logic signed [31:0] old,
                                                      longint target, longint n);
    longint d;
    d = target - longint'(old);
    return clamp32(longint'(old) + d / n);
  endfunction

  // apply one item to the stores and return the updated entries
  function automatic grad_result_t predict_gradients(grad_item_t it);
    grad_result_t r;
    logic signed [31:0] g [4];
    logic signed [31:0] w [4];
    logic signed [31:0] b [4];
    logic signed [63:0] prod;
    longint n;
    int row;
    int idx;
    g[0] = it.g0; g[1] = it.g1; g[2] = it.g2; g[3] = it.g3;
    n = (it.count == 0) ? 1 : longint'(it.count);
    for (int l = 0; l < 4; l++) begin
      row = int'(it.grp) * 4 + l;
      w[l] = '0;
      b[l] = '0;
      if (row < Rows) begin
        if (it.col < Cols) begin
          idx = row * Cols + int'(it.col);
          prod = 64'(g[l]) * 64'(it.x);
          w[l] = mean_update(weight_mean[idx], longint'(clamp32(prod >>> 24)), n);
          weight_mean[idx] = w[l];
        end
        if (it.col == 0) bias_mean[row] = mean_update(bias_mean[row], longint'(g[l]), n);
        b[l] = bias_mean[row];
      end
    end
    r = '{b[3], b[2], b[1], b[0], w[3], w[2], w[1], w[0]};
    return r;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic grad_item_t rand_item();
    grad_item_t it;
    it.grp = 4'($urandom_range(0, 15));
    // favor few addresses so entries accumulate and hit back to back
    it.col = ($urandom_range(0, 3) == 0) ? 6'd0 :
             ($urandom_range(0, 1) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63)));
    if ($urandom_range(0, 1)) it.grp = 4'($urandom_range(0, 1));
    it.g0 = rand_value(); it.g1 = rand_value();
    it.g2 = rand_value(); it.g3 = rand_value();
    it.x = rand_value();
    case ($urandom_range(0, 4))
      0: it.count = '0;
      1: it.count = 16'hffff;
      2: it.count = 16'($urandom);
      default: it.count = 16'($urandom_range(1, 20));
    endcase
    return it;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall pattern, plus a long hold-off window
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 3) != 0) || (cycles[9:8] == 2'b01);
  end

  // result checker
  always @(posedge clk) begin
    grad_result_t got;
    grad_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result transaction %h", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got.w0 !== exp_r.w0 || got.w1 !== exp_r.w1 || got.w2 !== exp_r.w2 ||
            got.w3 !== exp_r.w3 || got.b0 !== exp_r.b0 || got.b1 !== exp_r.b1 ||
            got.b2 !== exp_r.b2 || got.b3 !== exp_r.b3) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %h got %h", exp_r, got);
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    @(posedge rst_n);
    repeat (1400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one item until accepted; burst/gap shaping done by caller
  task automatic send_item(grad_item_t it, bit has_fixed, grad_result_t fixed);
    grad_result_t pred;
    in_tdata <= 192'(it);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = predict_gradients(it);
    if (has_fixed && pred !== fixed) begin
      mismatches++;
      $display("table row disagrees: %h vs %h", fixed, pred);
    end
    expected_results.push_back(pred);
  endtask

  task automatic maybe_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return;
    end
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
    burst = $urandom_range(0, 40);
  endtask

  initial begin
    stim_row_t table_rows [NumDirected];
    grad_item_t it;
    grad_result_t z;
    int burst;
    z = '0;
    foreach (weight_mean[i]) weight_mean[i] = '0;
    foreach (bias_mean[i]) bias_mean[i] = '0;

    // directed table
    for (int i = 0; i < NumDirected; i++) begin
      it = '0;
      it.count = 16'd1;
      table_rows[i].has_fixed = 1'b0;
      table_rows[i].fixed = z;
      case (i)
        0: table_rows[i].has_fixed = 1'b1;          // zero input after reset
        1: begin it.col = 6'd5; it.g0 = 32'sh7fffffff; it.x = 32'sh7fffffff; end
        2: begin it.col = 6'd5; it.g0 = 32'sh80000000; it.x = 32'sh7fffffff; end
        3: begin it.col = 6'd5; it.g1 = 32'sh80000000; it.x = 32'sh80000000; end
        4: begin it.grp = 4'd15; it.col = 6'd63; it.g3 = 32'sh7fffffff;
                 it.x = 32'sh01000000; it.count = '0; end  // zero count as one
        5: begin it.grp = 4'd15; it.col = 6'd63; it.g3 = 32'sh80000000;
                 it.x = 32'sh01000000; it.count = 16'hffff; end
        6: begin it.col = '0; it.g0 = 32'sh7fffffff; it.g1 = 32'sh80000000;
                 it.g2 = 32'sh01000000; it.g3 = -32'sh01000000; end
        7: begin it.col = '0; it.g0 = 32'sh80000000; it.g1 = 32'sh7fffffff;
                 it.count = 16'd2; end
        8: begin it.col = '0; it.g0 = -32'sd1; it.x = 32'sd1; it.count = 16'd3; end
        9: begin it.col = 6'd7; it.g2 = -32'sd1; it.x = 32'sd1; end
        10: begin it.col = 6'd7; it.g2 = 32'sh00000001; it.x = -32'sh7fffffff;
                  it.count = 16'hffff; end
        default: begin
          it.grp = i[3:0]; it.col = 6'(i); it.g0 = -i * 32'sh00100000;
          it.g1 = i * 32'sh00123456; it.x = 32'sh00c00000; it.count = 16'(i - 9);
        end
      endcase
      table_rows[i].item = it;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) send_item(table_rows[i].item, table_rows[i].has_fixed,
                                      table_rows[i].fixed);
    burst = 0;
    for (int i = 0; i < NumRandom; i++) begin
      maybe_gap(burst);
      send_item(rand_item(), 1'b0, z);
    end
    in_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== outer_product_gradient_running_mean_unit.f =====
rtl/opgrm_pkg.sv
rtl/opgrm_div.sv
rtl/opgrm_lane.sv
rtl/outer_product_gradient_running_mean_unit.sv
test/outer_product_gradient_running_mean_unit_tb.sv
